// ===== sv/msk_pkg.sv =====
// ----------------------------------------------------------------------------
// msk_pkg
// Shared types and codes for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package msk_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STAT_W  = 2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] value;
  } msk_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic [STAT_W-1:0]        status;
  } msk_rsp_t;

endpackage

// ===== sv/msk_ram.sv =====
// ----------------------------------------------------------------------------
// msk_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module msk_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/min_tracking_stack_top.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// Signed 32-bit stack that also reports its current minimum.
//
//   channel   handshake        word       direction
//   request   start / busy     req        in
//   result    done (strobe)    rsp        out
//
// A push gives its result in the cycle after it is taken; tops are held in
// registers so no memory read is needed. A pop passes through S_READ (busy
// high), where the new tops arrive from the value and minima memories as
// registered reads. Pushes and rejected operations sustain one word per
// cycle if idle. Reset clears both counts; memory contents need no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module min_tracking_stack_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  msk_pkg::msk_req_t req,
  output logic              done,
  output msk_pkg::msk_rsp_t rsp
);

  import msk_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                     state, state_next;
  logic [CW-1:0]            vc, vc_next;
  logic [CW-1:0]            mc, mc_next;
  logic signed [DATA_W-1:0] vtop, vtop_next;
  logic signed [DATA_W-1:0] mtop, mtop_next;
  logic                     min_pop, min_pop_next;
  logic                     done_next;
  msk_rsp_t                 rsp_next;

  logic                     v_we, m_we;
  logic [AW-1:0]            v_waddr, m_waddr;
  logic [CW-1:0]            vc_m2, mc_m2;
  logic [DATA_W-1:0]        v_rdata, m_rdata;
  logic [31:0]              cnt_ext;
  logic                     accept, full, min_push;

  assign busy    = (state == S_READ);
  assign accept  = start && !busy;
  assign full    = (vc == CW'(DEPTH));
  assign vc_m2   = vc - CW'(2);
  assign mc_m2   = mc - CW'(2);
  assign v_waddr = vc[AW-1:0];
  assign m_waddr = mc[AW-1:0];
  assign min_push = (mc == '0) || (req.value <= mtop);

  msk_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (req.value),
    .raddr (vc_m2[AW-1:0]),
    .rdata (v_rdata)
  );

  msk_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_minima_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (req.value),
    .raddr (mc_m2[AW-1:0]),
    .rdata (m_rdata)
  );

  always_comb begin
    state_next   = state;
    vc_next      = vc;
    mc_next      = mc;
    vtop_next    = vtop;
    mtop_next    = mtop;
    min_pop_next = min_pop;
    done_next    = 1'b0;
    v_we         = 1'b0;
    m_we         = 1'b0;
    rsp_next     = rsp;
    cnt_ext      = 32'(vc);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          if (req.func == FUNC_PUSH) begin
            if (full) begin
              rsp_next.status    = ST_FULL;
              rsp_next.top_value = vtop;
              rsp_next.min_value = (mc == '0) ? '0 : mtop;
              rsp_next.is_empty  = 1'b0;
              cnt_ext            = 32'(vc);
            end else begin
              v_we               = 1'b1;
              vc_next            = vc + CW'(1);
              vtop_next          = req.value;
              rsp_next.status    = ST_DONE;
              rsp_next.top_value = req.value;
              rsp_next.is_empty  = 1'b0;
              cnt_ext            = 32'(vc_next);
              if (min_push && (mc < CW'(DEPTH))) begin
                m_we               = 1'b1;
                mc_next            = mc + CW'(1);
                mtop_next          = req.value;
                rsp_next.min_value = req.value;
              end else begin
                rsp_next.min_value = mtop;
              end
            end
          end else begin
            if (vc == '0) begin
              rsp_next.status    = ST_EMPTY;
              rsp_next.top_value = '0;
              rsp_next.min_value = '0;
              rsp_next.is_empty  = 1'b1;
              cnt_ext            = '0;
            end else begin
              done_next    = 1'b0;
              state_next   = S_READ;
              vc_next      = vc - CW'(1);
              min_pop_next = (mc != '0) && (vtop == mtop);
              if ((mc != '0) && (vtop == mtop)) begin
                mc_next = mc - CW'(1);
              end
            end
          end
          rsp_next.count = cnt_ext[COUNT_W-1:0];
        end
      end
      S_READ: begin
        // new tops come out of the memories this cycle
        done_next  = 1'b1;
        state_next = S_IDLE;
        vtop_next  = v_rdata;
        if (min_pop) begin
          mtop_next = m_rdata;
        end
        rsp_next.status    = ST_DONE;
        rsp_next.is_empty  = (vc == '0);
        rsp_next.top_value = (vc == '0) ? '0 : v_rdata;
        if ((vc == '0) || (mc == '0)) begin
          rsp_next.min_value = '0;
        end else begin
          rsp_next.min_value = min_pop ? m_rdata : mtop;
        end
        rsp_next.count = cnt_ext[COUNT_W-1:0];
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      vc      <= '0;
      mc      <= '0;
      min_pop <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      vc      <= vc_next;
      mc      <= mc_next;
      min_pop <= min_pop_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    vtop <= vtop_next;
    mtop <= mtop_next;
    rsp  <= rsp_next;
  end

  // pop of a non-empty stack always finishes in the read cycle
  a_read_finishes: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("read cycle did not finish");

  a_pop_waits: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.func == FUNC_POP) && (vc != '0)) |=> (busy && !done))
    else $error("pop skipped the read cycle");

  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.func == FUNC_PUSH)) |=> (done && !busy))
    else $error("push result late");

  a_minima_bound: assert property (@(posedge clk) disable iff (rst)
    mc <= vc)
    else $error("minima count above value count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.is_empty) |-> ((rsp.top_value == '0) && (rsp.min_value == '0)))
    else $error("empty stack reports non-zero tops");

endmodule
